### rtl/tdpc_pkg.sv
// ----------------------------------------------------------------------------
// tdpc_pkg
// Shared widths, constants and controller/datapath interface types for the
// trial division prime counter.
// ----------------------------------------------------------------------------
package tdpc_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int COUNT_BITS  = 32;
   // odd divisors stay below 2^(VALUE_BITS/2) + 2
   localparam int DIV_BITS    = VALUE_BITS / 2 + 1;
   localparam int SQ_BITS     = VALUE_BITS + 2;
   localparam int STEP_BITS   = $clog2(VALUE_BITS);
   localparam int RSP_FIELD_W = 2 + COUNT_BITS;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [DIV_BITS-1:0]   FIRST_DIV  = DIV_BITS'(3);
   localparam logic [SQ_BITS-1:0]    FIRST_SQ   = SQ_BITS'(9);
   localparam logic [VALUE_BITS-1:0] VALUE_TWO  = VALUE_BITS'(2);
   localparam logic [STEP_BITS-1:0]  LAST_STEP  = STEP_BITS'(VALUE_BITS - 1);

   typedef struct packed {
      logic load;        // capture candidate, reset divisor
      logic start_div;   // begin remainder of candidate by divisor
      logic div_step;    // one restoring division step
      logic advance;     // next odd divisor and its square
      logic publish;     // update count and load result word
      logic prime;       // verdict for publish
   } tdpc_cmd_type;

   typedef struct packed {
      logic n_le1;
      logic n_is2;
      logic n_even;
      logic sq_gt_n;
      logic div_last;
      logic rem_zero;
   } tdpc_sts_type;

endpackage

### rtl/tdpc_datapath.sv
// ----------------------------------------------------------------------------
// tdpc_datapath
// Candidate, divisor, running square, bit-serial remainder unit, limit
// register, saturating prime count and result word register.
// ----------------------------------------------------------------------------
module tdpc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [tdpc_pkg::VALUE_BITS-1:0]   csr_wdata,
   input  logic [tdpc_pkg::VALUE_BITS-1:0]   req_tdata,
   input  tdpc_pkg::tdpc_cmd_type            cmd,
   output tdpc_pkg::tdpc_sts_type            sts,
   output logic [tdpc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   logic [tdpc_pkg::VALUE_BITS-1:0]  limit_ff, limit_in;
   logic [tdpc_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic [tdpc_pkg::VALUE_BITS-1:0]  n_ff, n_in;
   logic [tdpc_pkg::DIV_BITS-1:0]    d_ff, d_in;
   logic [tdpc_pkg::SQ_BITS-1:0]     sq_ff, sq_in;
   logic [tdpc_pkg::VALUE_BITS-1:0]  dvd_ff, dvd_in;
   logic [tdpc_pkg::DIV_BITS-1:0]    rem_ff, rem_in;
   logic [tdpc_pkg::STEP_BITS-1:0]   step_ff, step_in;
   logic [tdpc_pkg::RSP_TDATA_W-1:0] rsp_ff, rsp_in;

   logic [tdpc_pkg::DIV_BITS:0]      trial;
   logic [tdpc_pkg::DIV_BITS:0]      d_ext;
   logic                             beyond;
   logic                             bump;

   assign trial  = {rem_ff, dvd_ff[tdpc_pkg::VALUE_BITS-1]};
   assign d_ext  = {1'b0, d_ff};
   assign beyond = n_ff > limit_ff;
   assign bump   = cmd.prime && !beyond && (count_ff != tdpc_pkg::COUNT_MAX);

   always_comb begin
      limit_in = csr_wen ? csr_wdata : limit_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      count_in = count_ff;
      rsp_in   = rsp_ff;
      if (cmd.load) begin
         n_in  = req_tdata;
         d_in  = tdpc_pkg::FIRST_DIV;
         sq_in = tdpc_pkg::FIRST_SQ;
      end
      if (cmd.start_div) begin
         dvd_in  = n_ff;
         rem_in  = '0;
         step_in = '0;
      end
      if (cmd.div_step) begin
         dvd_in  = {dvd_ff[tdpc_pkg::VALUE_BITS-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (trial >= d_ext) begin
            rem_in = tdpc_pkg::DIV_BITS'(trial - d_ext);
         end else begin
            rem_in = trial[tdpc_pkg::DIV_BITS-1:0];
         end
      end
      if (cmd.advance) begin
         // (d+2)^2 = d^2 + 4d + 4
         d_in  = d_ff + tdpc_pkg::DIV_BITS'(2);
         sq_in = sq_ff + {{(tdpc_pkg::SQ_BITS-tdpc_pkg::DIV_BITS-2){1'b0}}, d_ff, 2'b00}
                 + tdpc_pkg::SQ_BITS'(4);
      end
      if (cmd.publish) begin
         count_in = bump ? count_ff + 1'b1 : count_ff;
         rsp_in   = tdpc_pkg::RSP_TDATA_W'({count_in, beyond, cmd.prime});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
         count_ff <= '0;
      end else begin
         limit_ff <= limit_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      d_ff    <= d_in;
      sq_ff   <= sq_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      sts.n_le1    = n_ff[tdpc_pkg::VALUE_BITS-1:1] == '0;
      sts.n_is2    = n_ff == tdpc_pkg::VALUE_TWO;
      sts.n_even   = !n_ff[0];
      sts.sq_gt_n  = sq_ff > {2'b00, n_ff};
      sts.div_last = step_ff == tdpc_pkg::LAST_STEP;
      sts.rem_zero = rem_ff == '0;
   end

   assign rsp_tdata = rsp_ff;

endmodule

### rtl/tdpc_ctrl.sv
// ----------------------------------------------------------------------------
// tdpc_ctrl
// Sequencer for the trial division loop and the result word handshake.
// ----------------------------------------------------------------------------
module tdpc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  tdpc_pkg::tdpc_sts_type sts,
   output tdpc_pkg::tdpc_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_TEST  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       prime_ff, prime_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in      = state_ff;
      prime_in      = prime_ff;
      cmd           = '0;
      cmd.prime     = prime_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.n_le1) begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else if (sts.n_is2) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else if (sts.n_even) begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else if (sts.sq_gt_n) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (sts.rem_zero) begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (!valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.publish) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prime_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prime_ff <= prime_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = valid_ff;

endmodule

### rtl/trial_division_prime_counter_unit.sv
// ----------------------------------------------------------------------------
// trial_division_prime_counter_unit
// Trial division primality test with a saturating count of primes that do
// not exceed a programmable limit.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one candidate word (req_tdata) per item.
//   rsp channel: one result word per candidate: is_prime, beyond_limit and
//   the prime count after that candidate.
//   csr: csr_wen/csr_wdata write the upper limit; write only while idle.
// Operation:
//   Candidates 0, 1, 2 and even numbers are decided in the check state.
//   Odd candidates try divisors 3, 5, 7 and so on while d*d <= n; each divisor
//   takes a bound check, a bit-serial remainder and a test.
//   One candidate is in work at a time.
// Reset: synchronous; clears the limit, the prime count and all control.
// Stall: a finished result waits in the output register; the next candidate
//   is accepted and processed meanwhile, and is held in the done state until
//   the waiting word is taken.
// ----------------------------------------------------------------------------
module trial_division_prime_counter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [tdpc_pkg::VALUE_BITS-1:0]   csr_wdata,   // upper_limit
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tdpc_pkg::VALUE_BITS-1:0]   req_tdata,   // candidate
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] is_prime, [1] beyond_limit, [33:2] prime_count, rest zero
   output logic [tdpc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   tdpc_pkg::tdpc_cmd_type cmd;
   tdpc_pkg::tdpc_sts_type sts;

   tdpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tdpc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_tvalid)
      else $error("result word not presented after publish");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new word accepted while candidate in work");

   a_publish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result word overwritten");

   a_step_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !(cmd.publish || cmd.advance || cmd.load))
      else $error("conflicting datapath commands");

endmodule
